/* sv/beeper_tone_queue_sequencer_assert.svh */
`ifndef BEEPER_TONE_QUEUE_SEQUENCER_ASSERT_SVH
`define BEEPER_TONE_QUEUE_SEQUENCER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define BTQS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("btqs assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define BTQS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("btqs assertion failed");

`endif

/* sv/btqs_pkg.sv */
package btqs_pkg;

    typedef enum logic [1:0] {
        OP_TICK       = 2'd0,
        OP_PLAY_NOW   = 2'd1,
        OP_ENQ_SCALED = 2'd2,
        OP_ENQ_RAW    = 2'd3
    } t_opcode;

    localparam logic [1:0] CFG_LENGTH_SCALE  = 2'd0;
    localparam logic [1:0] CFG_SPEAKER_PITCH = 2'd1;
    localparam logic [1:0] CFG_PITCH_OFFSET  = 2'd2;

    localparam int          CFG_W     = 7;
    localparam logic [12:0] DIVIDEND  = 13'd5000;
    localparam logic [3:0]  DIV_STEPS = 4'd13;
    localparam logic [3:0]  LEN_STEPS = 4'd8;

    typedef struct packed {
        t_opcode            opcode;
        logic [7:0]         frequency;
        logic [7:0]         duration;
        logic [7:0]         gap;
        logic [7:0]         repeats;
        logic signed [7:0]  ramp;
        logic               audible;
    } t_cmd;

    typedef struct packed {
        logic        beep_on;
        logic [12:0] period_divider;
        logic        dropped;
        logic        queue_empty;
    } t_result;

    typedef struct packed {
        logic [7:0] freq;
        logic [7:0] length;
        logic [7:0] pause;
        logic [7:0] repeats;
        logic [7:0] ramp;
    } t_entry;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TICK,
        ST_SCALE,
        ST_MUL,
        ST_DIV,
        ST_LOAD,
        ST_EXEC
    } t_state;

endpackage

/* sv/beeper_tone_queue_sequencer.sv */
// Beeper tone sequencer. A command is taken when i_start is high and o_busy is low; its result
// appears on o_result for exactly one cycle, flagged by o_done, and cannot be held off by the
// receiver, so it must be captured in that cycle. A new command may be presented in the o_done
// cycle. An audible playing tick computes its period divider with the bit-serial 5000/freq
// divider (one quotient bit per cycle, 13 bits). Other ticks end in ST_TICK or in ST_LOAD.
// A scaled enqueue or play-now goes through ST_SCALE to ST_EXEC, via ST_MUL when the length is
// multiplied (shift-add, one multiplier bit per cycle) or ST_DIV when it is divided (the same
// divider, 8 steps). A raw enqueue goes straight to ST_EXEC. Configuration writes via
// i_cfg_we are taken at any edge and must only be issued while the block is idle.
module beeper_tone_queue_sequencer
    import btqs_pkg::*;
#(
    parameter int QUEUE_DEPTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    output logic             o_busy,
    input  t_cmd             i_cmd,
    output logic             o_done,
    output t_result          o_result,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_addr,
    input  logic [CFG_W-1:0] i_cfg_data
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

    t_state             r_state, n_state;
    t_cmd               r_cmd, n_cmd;
    logic               r_done, n_done;
    logic signed [3:0]  r_scale;
    logic [6:0]         r_pitch;
    logic [6:0]         r_offset;
    logic [7:0]         r_cur_freq, n_cur_freq;
    logic [7:0]         r_ticks, n_ticks;
    logic [7:0]         r_pause, n_pause;
    logic [7:0]         r_cur_ramp, n_cur_ramp;
    logic [PTR_W-1:0]   r_rptr, n_rptr;
    logic [PTR_W-1:0]   r_wptr, n_wptr;
    logic               r_speaker, n_speaker;
    logic [12:0]        r_divider, n_divider;
    logic               r_dropped, n_dropped;
    logic [7:0]         r_len, n_len;
    logic [12:0]        r_quo, n_quo;
    logic [7:0]         r_rem, n_rem;
    logic [7:0]         r_den, n_den;
    logic [3:0]         r_cnt, n_cnt;
    logic [11:0]        r_acc, n_acc;
    logic [11:0]        r_mcand, n_mcand;
    logic [3:0]         r_mplier, n_mplier;

    t_entry             r_mem [QUEUE_DEPTH];
    t_entry             r_rd_data;
    logic               mem_we;
    logic [PTR_W-1:0]   mem_addr;
    t_entry             mem_wdata;

    logic               accept;
    logic [7:0]         tone_f;
    logic [8:0]         trial;
    logic [8:0]         diff;
    logic               ge;
    logic [12:0]        q_next;
    logic [7:0]         rem_next;
    logic [PTR_W-1:0]   rptr_inc, wptr_inc;
    logic               full;

    assign accept   = i_start && !o_busy;
    assign o_busy   = (r_state != ST_IDLE);
    assign o_done   = r_done;
    assign o_result = '{beep_on:        r_speaker,
                        period_divider: r_divider,
                        dropped:        r_dropped,
                        queue_empty:    (r_rptr == r_wptr)};

    assign tone_f = (r_cmd.audible && r_cmd.frequency != 8'd0)
                  ? 8'(r_cmd.frequency + {1'b0, r_pitch} + {1'b0, r_offset}) : 8'd0;

    // restoring divide step: one quotient bit per cycle
    assign trial    = {r_rem, r_quo[12]};
    assign diff     = trial - {1'b0, r_den};
    assign ge       = (trial >= {1'b0, r_den});
    assign q_next   = {r_quo[11:0], ge};
    assign rem_next = ge ? diff[7:0] : trial[7:0];

    assign rptr_inc = (r_rptr == PTR_LAST) ? '0 : r_rptr + 1'b1;
    assign wptr_inc = (r_wptr == PTR_LAST) ? '0 : r_wptr + 1'b1;
    assign full     = (wptr_inc == r_rptr);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale  <= '0;
            r_pitch  <= '0;
            r_offset <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_LENGTH_SCALE:  r_scale  <= i_cfg_data[3:0];
                CFG_SPEAKER_PITCH: r_pitch  <= i_cfg_data[6:0];
                CFG_PITCH_OFFSET:  r_offset <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_addr] <= mem_wdata;
        end
        r_rd_data <= r_mem[r_rptr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_done     <= 1'b0;
            r_cur_freq <= '0;
            r_ticks    <= '0;
            r_pause    <= '0;
            r_cur_ramp <= '0;
            r_rptr     <= '0;
            r_wptr     <= '0;
            r_speaker  <= 1'b0;
            r_divider  <= '0;
            r_dropped  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_done     <= n_done;
            r_cur_freq <= n_cur_freq;
            r_ticks    <= n_ticks;
            r_pause    <= n_pause;
            r_cur_ramp <= n_cur_ramp;
            r_rptr     <= n_rptr;
            r_wptr     <= n_wptr;
            r_speaker  <= n_speaker;
            r_divider  <= n_divider;
            r_dropped  <= n_dropped;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_len    <= n_len;
        r_quo    <= n_quo;
        r_rem    <= n_rem;
        r_den    <= n_den;
        r_cnt    <= n_cnt;
        r_acc    <= n_acc;
        r_mcand  <= n_mcand;
        r_mplier <= n_mplier;
    end

    always_comb begin
        n_state    = r_state;
        n_done     = 1'b0;
        n_cmd      = r_cmd;
        n_cur_freq = r_cur_freq;
        n_ticks    = r_ticks;
        n_pause    = r_pause;
        n_cur_ramp = r_cur_ramp;
        n_rptr     = r_rptr;
        n_wptr     = r_wptr;
        n_speaker  = r_speaker;
        n_divider  = r_divider;
        n_dropped  = r_dropped;
        n_len      = r_len;
        n_quo      = r_quo;
        n_rem      = r_rem;
        n_den      = r_den;
        n_cnt      = r_cnt;
        n_acc      = r_acc;
        n_mcand    = r_mcand;
        n_mplier   = r_mplier;
        mem_we     = 1'b0;
        mem_addr   = r_wptr;
        mem_wdata  = '{freq: tone_f, length: r_len, pause: r_cmd.gap,
                       repeats: r_cmd.repeats, ramp: r_cmd.ramp};

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_cmd     = i_cmd;
                    n_dropped = 1'b0;
                    unique case (i_cmd.opcode)
                        OP_TICK:    n_state = ST_TICK;
                        OP_ENQ_RAW: n_state = ST_EXEC;
                        default:    n_state = ST_SCALE;
                    endcase
                end
            end

            ST_TICK: begin
                if (r_ticks != 8'd0) begin
                    if (r_cur_freq != 8'd0) begin
                        n_quo   = DIVIDEND;
                        n_rem   = '0;
                        n_den   = r_cur_freq;
                        n_cnt   = DIV_STEPS;
                        n_state = ST_DIV;
                    end else begin
                        n_ticks    = r_ticks - 8'd1;
                        n_cur_freq = r_cur_freq + r_cur_ramp;
                        n_state    = ST_IDLE;
                        n_done     = 1'b1;
                    end
                end else if (r_pause != 8'd0) begin
                    n_speaker = 1'b0;
                    n_pause   = r_pause - 8'd1;
                    n_state   = ST_IDLE;
                    n_done    = 1'b1;
                end else if (r_rptr != r_wptr) begin
                    // read data for the head entry lands at this edge
                    n_state = ST_LOAD;
                end else begin
                    n_speaker = 1'b0;
                    n_state   = ST_IDLE;
                    n_done    = 1'b1;
                end
            end

            ST_SCALE: begin
                if (r_scale < 0) begin
                    // dividend sits at the top so the quotient fills the low byte in 8 steps
                    n_quo   = {r_cmd.duration, 5'd0};
                    n_rem   = '0;
                    n_den   = {4'd0, 4'd1 - r_scale};
                    n_cnt   = LEN_STEPS;
                    n_state = ST_DIV;
                end else if (r_scale > 0) begin
                    n_acc    = '0;
                    n_mcand  = {4'd0, r_cmd.duration};
                    n_mplier = 4'd1 + r_scale;
                    n_state  = ST_MUL;
                end else begin
                    n_len   = r_cmd.duration;
                    n_state = ST_EXEC;
                end
            end

            ST_MUL: begin
                if (r_mplier == 4'd0) begin
                    n_len   = (r_acc > 12'd255) ? 8'd255 : r_acc[7:0];
                    n_state = ST_EXEC;
                end else begin
                    if (r_mplier[0]) begin
                        n_acc = r_acc + r_mcand;
                    end
                    n_mcand  = {r_mcand[10:0], 1'b0};
                    n_mplier = {1'b0, r_mplier[3:1]};
                end
            end

            ST_DIV: begin
                n_quo = q_next;
                n_rem = rem_next;
                n_cnt = r_cnt - 4'd1;
                if (r_cnt == 4'd1) begin
                    if (r_cmd.opcode == OP_TICK) begin
                        n_divider  = q_next;
                        n_speaker  = 1'b1;
                        n_ticks    = r_ticks - 8'd1;
                        n_cur_freq = r_cur_freq + r_cur_ramp;
                        n_state    = ST_IDLE;
                        n_done     = 1'b1;
                    end else begin
                        n_len   = q_next[7:0];
                        n_state = ST_EXEC;
                    end
                end
            end

            ST_LOAD: begin
                n_cur_freq = r_rd_data.freq;
                n_ticks    = r_rd_data.length;
                n_cur_ramp = r_rd_data.ramp;
                n_pause    = r_rd_data.pause;
                if (r_rd_data.freq == 8'd0 || r_rd_data.length == 8'd0) begin
                    n_speaker = 1'b0;
                end
                if (r_rd_data.repeats != 8'd0) begin
                    mem_we            = 1'b1;
                    mem_addr          = r_rptr;
                    mem_wdata         = r_rd_data;
                    mem_wdata.repeats = r_rd_data.repeats - 8'd1;
                end else begin
                    n_rptr = rptr_inc;
                end
                n_state = ST_IDLE;
                n_done  = 1'b1;
            end

            ST_EXEC: begin
                unique case (r_cmd.opcode)
                    OP_PLAY_NOW: begin
                        n_cur_freq = tone_f;
                        n_ticks    = r_len;
                        n_pause    = r_cmd.gap;
                        n_cur_ramp = r_cmd.ramp;
                        // flush, then queue the remaining repetitions at the head
                        if (r_cmd.repeats != 8'd0) begin
                            mem_we            = 1'b1;
                            mem_addr          = r_rptr;
                            mem_wdata.repeats = r_cmd.repeats - 8'd1;
                            n_wptr            = rptr_inc;
                        end else begin
                            n_wptr = r_rptr;
                        end
                    end
                    OP_ENQ_SCALED: begin
                        n_dropped = full;
                        if (!full) begin
                            mem_we = 1'b1;
                            n_wptr = wptr_inc;
                        end
                    end
                    OP_ENQ_RAW: begin
                        n_dropped = full;
                        mem_wdata = '{freq: r_cmd.frequency, length: r_cmd.duration,
                                      pause: 8'd0, repeats: 8'd0, ramp: 8'd0};
                        if (!full) begin
                            mem_we = 1'b1;
                            n_wptr = wptr_inc;
                        end
                    end
                    default: ;
                endcase
                n_state = ST_IDLE;
                n_done  = 1'b1;
            end

            default: n_state = ST_IDLE;
        endcase
    end

endmodule

/* sv/btqs_checker.sv */
`include "beeper_tone_queue_sequencer_assert.svh"

module btqs_checker
    import btqs_pkg::*;
(
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    i_start,
    input logic    o_busy,
    input logic    o_done,
    input t_result o_result
);

    `BTQS_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, i_start && !o_busy, o_busy)
    `BTQS_ASSERT_NEXT(a_done_single, i_clk, i_rst_n, o_done, !o_done)
    `BTQS_ASSERT_NOW(a_done_idle, i_clk, i_rst_n, o_done, !o_busy)
    `BTQS_ASSERT_NOW(a_drop_full, i_clk, i_rst_n, o_done && o_result.dropped, !o_result.queue_empty)
    `BTQS_ASSERT_NOW(a_div_range, i_clk, i_rst_n, o_done, o_result.period_divider <= DIVIDEND)

endmodule

bind beeper_tone_queue_sequencer btqs_checker u_btqs_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_start  (i_start),
    .o_busy   (o_busy),
    .o_done   (o_done),
    .o_result (o_result)
);

/* tb/tone_sequence_checker.sv */
module tone_sequence_checker
    import btqs_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic             i_busy,
    input  t_cmd             i_cmd,
    input  logic             i_done,
    input  t_result          i_result,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_addr,
    input  logic [CFG_W-1:0] i_cfg_data,
    output int               o_mismatches,
    output int               o_pending
);

    localparam int DEPTH = 8;

    logic signed [3:0] len_scale;
    logic [6:0]        user_pitch;
    logic [6:0]        pitch_comp;

    logic [7:0]  cur_freq;
    logic [7:0]  ticks_left;
    logic [7:0]  pause_left;
    logic [7:0]  cur_ramp;
    logic [2:0]  rd_ptr;
    logic [2:0]  wr_ptr;
    t_entry      tone_q [DEPTH];
    logic        spk_on;
    logic [12:0] divider;

    t_result expected_status_q [$];

    function automatic logic [7:0] scaled_length(logic [7:0] len);
        int n;
        int r;
        n = len_scale;
        r = len;
        if (n < 0) begin
            r = r / (1 - n);
        end else if (n > 0) begin
            r = r * (1 + n);
            if (r > 255) r = 255;
        end
        return r[7:0];
    endfunction

    function automatic logic [7:0] tone_freq(logic [7:0] f, logic aud);
        int s;
        if (!aud || f == 8'd0) return 8'd0;
        s = f + user_pitch + pitch_comp;
        return s[7:0];
    endfunction

    // Refuse the entry when one more would make the pointers meet
    function automatic bit push_tone(t_entry e);
        logic [2:0] nxt;
        nxt = wr_ptr + 3'd1;
        if (nxt == rd_ptr) return 1'b0;
        tone_q[wr_ptr] = e;
        wr_ptr = nxt;
        return 1'b1;
    endfunction

    function automatic void play_tick();
        t_entry e;
        if (ticks_left != 8'd0) begin
            // a silent tone still counts down and ramps
            if (cur_freq != 8'd0) begin
                divider = DIVIDEND / cur_freq;
                spk_on = 1'b1;
            end
            ticks_left = ticks_left - 8'd1;
            cur_freq = cur_freq + cur_ramp;
        end else if (pause_left != 8'd0) begin
            spk_on = 1'b0;
            pause_left = pause_left - 8'd1;
        end else if (rd_ptr != wr_ptr) begin
            e = tone_q[rd_ptr];
            cur_freq = e.freq;
            ticks_left = e.length;
            cur_ramp = e.ramp;
            pause_left = e.pause;
            if (e.freq == 8'd0 || e.length == 8'd0) spk_on = 1'b0;
            if (e.repeats != 8'd0) begin
                tone_q[rd_ptr].repeats = e.repeats - 8'd1;
            end else begin
                rd_ptr = rd_ptr + 3'd1;
            end
        end else begin
            spk_on = 1'b0;
        end
    endfunction

    function automatic t_result predict_beeper_status(t_cmd c);
        t_result r;
        logic    full;
        full = 1'b0;
        case (c.opcode)
            OP_TICK: begin
                play_tick();
            end
            OP_PLAY_NOW: begin
                cur_freq = tone_freq(c.frequency, c.audible);
                ticks_left = scaled_length(c.duration);
                pause_left = c.gap;
                cur_ramp = c.ramp;
                wr_ptr = rd_ptr;
                // queue the remaining plays as one entry
                if (c.repeats != 8'd0) begin
                    void'(push_tone('{freq: cur_freq, length: ticks_left, pause: c.gap,
                                      repeats: c.repeats - 8'd1, ramp: c.ramp}));
                end
            end
            OP_ENQ_SCALED: begin
                full = !push_tone('{freq: tone_freq(c.frequency, c.audible),
                                    length: scaled_length(c.duration), pause: c.gap,
                                    repeats: c.repeats, ramp: c.ramp});
            end
            OP_ENQ_RAW: begin
                full = !push_tone('{freq: c.frequency, length: c.duration, pause: 8'd0,
                                    repeats: 8'd0, ramp: 8'd0});
            end
        endcase
        r.beep_on = spk_on;
        r.period_divider = divider;
        r.dropped = full;
        r.queue_empty = (rd_ptr == wr_ptr);
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            len_scale = '0;
            user_pitch = '0;
            pitch_comp = '0;
            cur_freq = '0;
            ticks_left = '0;
            pause_left = '0;
            cur_ramp = '0;
            rd_ptr = '0;
            wr_ptr = '0;
            spk_on = 1'b0;
            divider = '0;
            foreach (tone_q[k]) tone_q[k] = '0;
            expected_status_q.delete();
            o_pending <= 0;
        end else begin
            // compare first: a new command may be taken in the same cycle as a result
            if (i_done) begin
                if (expected_status_q.size() == 0) begin
                    $error("status transfer with nothing expected");
                    o_mismatches++;
                end else begin
                    want = expected_status_q.pop_front();
                    if (i_result.beep_on !== want.beep_on) begin
                        $error("beep_on expected %0d got %0d",
                               want.beep_on, i_result.beep_on);
                        o_mismatches++;
                    end
                    if (i_result.period_divider !== want.period_divider) begin
                        $error("period_divider expected %0d got %0d",
                               want.period_divider, i_result.period_divider);
                        o_mismatches++;
                    end
                    if (i_result.dropped !== want.dropped) begin
                        $error("dropped expected %0d got %0d", want.dropped, i_result.dropped);
                        o_mismatches++;
                    end
                    if (i_result.queue_empty !== want.queue_empty) begin
                        $error("queue_empty expected %0d got %0d",
                               want.queue_empty, i_result.queue_empty);
                        o_mismatches++;
                    end
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_LENGTH_SCALE:  len_scale = i_cfg_data[3:0];
                    CFG_SPEAKER_PITCH: user_pitch = i_cfg_data[6:0];
                    CFG_PITCH_OFFSET:  pitch_comp = i_cfg_data[6:0];
                    default: ;
                endcase
            end
            if (i_start && !i_busy) begin
                expected_status_q.push_back(predict_beeper_status(i_cmd));
            end
            o_pending <= expected_status_q.size();
        end
    end

endmodule

/* tb/beeper_tone_queue_sequencer_tb.sv */
module beeper_tone_queue_sequencer_tb;
    import btqs_pkg::*;

    localparam int STALL_LIMIT     = 2000;
    localparam int ITEMS_PER_PHASE = 175;
    localparam int NUM_PHASES      = 6;
    localparam int CMD_W           = $bits(t_cmd);

    logic             i_clk      = 1'b0;
    logic             i_rst_n    = 1'b0;
    logic             i_start    = 1'b0;
    t_cmd             i_cmd      = '0;
    logic             i_cfg_we   = 1'b0;
    logic [1:0]       i_cfg_addr = CFG_LENGTH_SCALE;
    logic [CFG_W-1:0] i_cfg_data = '0;
    logic             o_busy;
    logic             o_done;
    t_result          o_result;

    int mismatches;
    int pending;
    int stall_cycles = 0;
    int sent         = 0;
    int idle_pct     = 0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    beeper_tone_queue_sequencer uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_start),
        .o_busy     (o_busy),
        .i_cmd      (i_cmd),
        .o_done     (o_done),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data)
    );

    tone_sequence_checker chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (i_start),
        .i_busy       (o_busy),
        .i_cmd        (i_cmd),
        .i_done       (o_done),
        .i_result     (o_result),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_data   (i_cfg_data),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    // Abort when nothing has been transferred for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_start && !o_busy) || o_done || i_cfg_we) begin
            stall_cycles <= 0;
        end else if (stall_cycles == STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    function automatic t_cmd make_tone(t_opcode op, logic [7:0] f, logic [7:0] dur,
                                       logic [7:0] gap, logic [7:0] rep, int ramp,
                                       logic aud);
        t_cmd c;
        c.opcode = op;
        c.frequency = f;
        c.duration = dur;
        c.gap = gap;
        c.repeats = rep;
        c.ramp = 8'(ramp);
        c.audible = aud;
        return c;
    endfunction

    // Short tones unless any is set, so that queued entries drain within a burst
    function automatic t_cmd random_tone(t_opcode op, bit any);
        t_cmd c;
        c = CMD_W'({$urandom, $urandom});
        c.opcode = op;
        if (!any) begin
            c.duration = 8'($urandom_range(0, 4));
            c.gap = 8'($urandom_range(0, 2));
            c.repeats = ($urandom_range(0, 19) == 0) ? 8'($urandom_range(3, 255))
                                                     : 8'($urandom_range(0, 2));
            c.audible = ($urandom_range(0, 5) != 0);
        end
        return c;
    endfunction

    task automatic send_cmd(t_cmd c);
        if ($urandom_range(0, 99) < idle_pct) begin
            i_start <= 1'b0;
            repeat ($urandom_range(1, 20)) @(posedge i_clk);
        end
        i_start <= 1'b1;
        i_cmd <= c;
        do begin
            @(posedge i_clk);
        end while (o_busy);
        sent++;
    endtask

    task automatic wait_drain();
        i_start <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (pending != 0);
    endtask

    task automatic write_config(logic signed [3:0] scale, logic [6:0] pitch,
                                logic [6:0] offset);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= CFG_LENGTH_SCALE;
        i_cfg_data <= {3'b000, scale};
        @(posedge i_clk);
        i_cfg_addr <= CFG_SPEAKER_PITCH;
        i_cfg_data <= pitch;
        @(posedge i_clk);
        i_cfg_addr <= CFG_PITCH_OFFSET;
        i_cfg_data <= offset;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic random_burst();
        int kind;
        kind = $urandom_range(0, 99);
        if (kind < 65) begin
            repeat ($urandom_range(1, 4)) begin
                send_cmd(random_tone(($urandom_range(0, 4) == 0) ? OP_ENQ_RAW
                                                                 : OP_ENQ_SCALED, 1'b0));
            end
            repeat ($urandom_range(4, 30)) send_cmd(random_tone(OP_TICK, 1'b1));
        end else if (kind < 85) begin
            send_cmd(random_tone(OP_PLAY_NOW, 1'b0));
            repeat ($urandom_range(2, 15)) send_cmd(random_tone(OP_TICK, 1'b1));
        end else begin
            send_cmd(random_tone(t_opcode'($urandom_range(0, 3)), 1'b1));
        end
    endtask

    initial begin
        int  quota;
        bit  paused;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_cmd(make_tone(OP_TICK, 8'd0, 8'd0, 8'd0, 8'd0, 0, 1'b0));
        send_cmd(make_tone(OP_ENQ_RAW, 8'd255, 8'd2, 8'd0, 8'd0, 0, 1'b0));
        // zero-length entry turns the speaker off on load
        send_cmd(make_tone(OP_ENQ_RAW, 8'd17, 8'd0, 8'd9, 8'd3, 5, 1'b1));
        send_cmd(make_tone(OP_ENQ_SCALED, 8'd0, 8'd2, 8'd1, 8'd1, -128, 1'b1));
        send_cmd(make_tone(OP_ENQ_SCALED, 8'd200, 8'd1, 8'd0, 8'd0, 5, 1'b0));
        send_cmd(make_tone(OP_ENQ_SCALED, 8'd1, 8'd3, 8'd2, 8'd0, 127, 1'b1));
        send_cmd(make_tone(OP_ENQ_SCALED, 8'd255, 8'd255, 8'd255, 8'd255, -1, 1'b1));
        send_cmd(make_tone(OP_ENQ_RAW, 8'd128, 8'd1, 8'd0, 8'd0, 0, 1'b1));
        // queue is full now: both must be dropped
        send_cmd(make_tone(OP_ENQ_SCALED, 8'd50, 8'd1, 8'd0, 8'd0, 0, 1'b1));
        send_cmd(make_tone(OP_ENQ_RAW, 8'd50, 8'd1, 8'd0, 8'd0, 0, 1'b1));
        repeat (8) send_cmd(make_tone(OP_TICK, 8'd0, 8'd0, 8'd0, 8'd0, 0, 1'b0));
        send_cmd(make_tone(OP_PLAY_NOW, 8'd255, 8'd255, 8'd255, 8'd255, 127, 1'b1));
        repeat (2) send_cmd(make_tone(OP_TICK, 8'd255, 8'd255, 8'd255, 8'd255, -1, 1'b1));
        send_cmd(make_tone(OP_PLAY_NOW, 8'd100, 8'd2, 8'd0, 8'd0, -128, 1'b1));
        repeat (4) send_cmd(make_tone(OP_TICK, 8'd0, 8'd0, 8'd0, 8'd0, 0, 1'b0));

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            // change settings only with nothing in flight
            if (ph != 0) begin
                wait_drain();
                case (ph)
                    1: write_config(4'sd4, 7'd127, 7'd127);
                    2: write_config(-4'sd4, 7'd0, 7'd0);
                    3: write_config(4'($urandom_range(0, 8) - 4), 7'($urandom_range(0, 127)),
                                    7'($urandom_range(0, 127)));
                    4: write_config(4'sd7, 7'd1, 7'd126);
                    default: write_config(-4'sd8, 7'($urandom_range(0, 127)),
                                          7'($urandom_range(0, 127)));
                endcase
            end
            case (ph)
                1, 4: idle_pct = 61;
                3, 5: idle_pct = 23;
                default: idle_pct = 0;
            endcase
            quota = sent + ITEMS_PER_PHASE;
            paused = 1'b0;
            while (sent < quota) begin
                random_burst();
                if (!paused && sent > quota - ITEMS_PER_PHASE / 2) begin
                    wait_drain();
                    paused = 1'b1;
                end
            end
        end

        wait_drain();
        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
